@@ design/vls_pkg.sv @@
// Package: shared constants for the voxel line-of-sight block.
package vls_pkg;

  localparam int MAX_DIM   = 32;
  localparam int FRAC_BITS = 8;

  localparam int COORD_W = 13;
  localparam int INDEX_W = 15;
  localparam int DIM_W   = 6;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEPTH  = 2'd2;

  localparam logic [1:0] CAUSE_ENDPOINT = 2'd0;
  localparam logic [1:0] CAUSE_PATH     = 2'd1;
  localparam logic [1:0] CAUSE_END      = 2'd2;
  localparam logic [1:0] CAUSE_LEFT     = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

@@ design/vls_if.sv @@
// Interfaces: the input and result channels of the voxel line-of-sight block.
interface vls_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [14:0] cell_index;
  logic        solid_flag;
  logic [12:0] start_x;
  logic [12:0] start_y;
  logic [12:0] start_z;
  logic [12:0] end_x;
  logic [12:0] end_y;
  logic [12:0] end_z;

  modport source(output valid, command, cell_index, solid_flag, start_x, start_y, start_z,
                 end_x, end_y, end_z, input ready);
  modport sink(input valid, command, cell_index, solid_flag, start_x, start_y, start_z,
               end_x, end_y, end_z, output ready);
endinterface

interface vls_out_if;
  logic       valid;
  logic       ready;
  logic       blocked;
  logic [1:0] stop_cause;

  modport source(output valid, blocked, stop_cause, input ready);
  modport sink(input valid, blocked, stop_cause, output ready);
endinterface

@@ design/voxel_line_of_sight.sv @@
// Top level: voxel line-of-sight block with its solid map memory and DDA walker.
//
//  channel     | dir | word contents
//  ------------+-----+-----------------------------------------------------------
//  query_in    | in  | command, cell_index, solid_flag, start_x/y/z, end_x/y/z
//  result_out  | out | blocked, stop_cause (one word per query, none per write)
//  cfg_*       | in  | plain write port, cfg_index 0..2 selects width/height/depth
//
// After reset the map is swept clear, one cell a cycle over all 32768 cells, while
// query_in.ready stays low. Configuration writes are taken during the sweep.
// A write word passes ST_WPRE1, ST_WPRE2 and ST_WRITE before the next accept. A
// query runs the endpoint checks (ST_PREP, ST_EP1, ST_EP2, ST_EPCHK), the setup
// of cross products on the one shared multiplier (ST_MUL), then per walked cell a
// map read (ST_WRD) and a compare and step (ST_WCHK), and loads the result in ST_DONE.
// The walk visits at most about three times the grid dimension cells.
// A finished result waits in the output register; the next word is taken while it
// waits, and a second result holds the walker until the first one is taken.
module voxel_line_of_sight (
  input  logic              clk,
  input  logic              rst,
  vls_in_if.sink            query_in,
  vls_out_if.source         result_out,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data
);

  localparam int MAP_CELLS = vls_pkg::MAX_DIM * vls_pkg::MAX_DIM * vls_pkg::MAX_DIM;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int ONE_CELL  = 1 << vls_pkg::FRAC_BITS;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WPRE1 = 4'd2;
  localparam logic [3:0] ST_WPRE2 = 4'd3;
  localparam logic [3:0] ST_WRITE = 4'd4;
  localparam logic [3:0] ST_PREP  = 4'd5;
  localparam logic [3:0] ST_EP1   = 4'd6;
  localparam logic [3:0] ST_EP2   = 4'd7;
  localparam logic [3:0] ST_EPCHK = 4'd8;
  localparam logic [3:0] ST_MUL   = 4'd9;
  localparam logic [3:0] ST_WRD   = 4'd10;
  localparam logic [3:0] ST_WCHK  = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // Cross products are kept for the ordered axis pairs 01,10,02,20,12,21.
  function automatic logic [1:0] pair_a(input logic [2:0] k);
    case (k)
      3'd0, 3'd2: pair_a = 2'd0;
      3'd1, 3'd4: pair_a = 2'd1;
      default:    pair_a = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] k);
    case (k)
      3'd1, 3'd3: pair_b = 2'd0;
      3'd0, 3'd5: pair_b = 2'd1;
      default:    pair_b = 2'd2;
    endcase
  endfunction

  function automatic logic [5:0] eff_dim(input logic [5:0] v);
    if (v == 6'd0) begin
      eff_dim = 6'd1;
    end else if (v > 6'(vls_pkg::MAX_DIM)) begin
      eff_dim = 6'(vls_pkg::MAX_DIM);
    end else begin
      eff_dim = v;
    end
  endfunction

  function automatic logic [4:0] clamp_c(input logic [4:0] c, input logic [5:0] dim);
    if ({1'b0, c} >= dim) begin
      clamp_c = 5'(dim - 6'd1);
    end else begin
      clamp_c = c;
    end
  endfunction

  logic [3:0]  state;
  logic [5:0]  dim [3];
  logic [10:0] plane;
  logic [15:0] cells;
  logic [14:0] clr_cnt;

  logic        flag_r;
  logic [14:0] idx_r;
  logic [12:0] s_r [3];
  logic [12:0] e_r [3];
  logic signed [6:0] g [3];
  logic [4:0]  ge [3];
  logic        dir_pos [3];
  logic [12:0] ad [3];
  logic [13:0] n [3];
  logic [26:0] p [6];
  logic [2:0]  mcnt;
  logic        start_solid;
  logic [1:0]  cause;

  logic        out_valid;
  logic        out_blocked;
  logic [1:0]  out_cause;
  logic        out_load;

  // Solid map memory.
  logic        mem [MAP_CELLS];
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic        rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Dimensions and the derived plane and cell counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim[0] <= 6'd1;
      dim[1] <= 6'd1;
      dim[2] <= 6'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        vls_pkg::CFG_WIDTH:  dim[0] <= eff_dim(cfg_data);
        vls_pkg::CFG_HEIGHT: dim[1] <= eff_dim(cfg_data);
        vls_pkg::CFG_DEPTH:  dim[2] <= eff_dim(cfg_data);
        default: ;
      endcase
    end
    plane <= 11'(dim[0]) * 11'(dim[1]);
    cells <= 16'(plane) * 16'(dim[2]);
  end

  // Coordinate selection for the map read, then one linear index computation.
  logic [4:0]  rx, ry, rz;
  logic [15:0] lin_sum;

  always_comb begin
    unique case (state)
      ST_EP1: begin
        rx = clamp_c(s_r[0][12:8], dim[0]);
        ry = clamp_c(s_r[1][12:8], dim[1]);
        rz = clamp_c(s_r[2][12:8], dim[2]);
      end
      ST_EP2: begin
        rx = clamp_c(e_r[0][12:8], dim[0]);
        ry = clamp_c(e_r[1][12:8], dim[1]);
        rz = clamp_c(e_r[2][12:8], dim[2]);
      end
      default: begin
        rx = g[0][4:0];
        ry = g[1][4:0];
        rz = g[2][4:0];
      end
    endcase
    lin_sum   = 16'(rx) + 16'(dim[0]) * 16'(ry) + 16'(plane) * 16'(rz);
    mem_raddr = lin_sum[ADDR_W-1:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = flag_r;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = 1'b0;
    end else if (state == ST_WRITE) begin
      mem_we = ({1'b0, idx_r} < cells);
    end
  end

  // Walk decisions.
  logic       ins;
  logic       at_end;
  logic       e01, e02, e12;
  logic [1:0] ax;
  logic signed [6:0] g_new [3];
  logic       ins_new;

  always_comb begin
    ins = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (g[a] < 7'sd0 || g[a] >= $signed({1'b0, dim[a]})) begin
        ins = 1'b0;
      end
    end
    at_end = (g[0] == $signed({2'b00, ge[0]})) && (g[1] == $signed({2'b00, ge[1]})) &&
             (g[2] == $signed({2'b00, ge[2]}));
    e01 = (ad[0] != 13'd0) && ((ad[1] == 13'd0) || (p[0] < p[1]));
    e02 = (ad[0] != 13'd0) && ((ad[2] == 13'd0) || (p[2] < p[3]));
    e12 = (ad[1] != 13'd0) && ((ad[2] == 13'd0) || (p[4] < p[5]));
    if (e01) begin
      ax = e02 ? 2'd0 : 2'd2;
    end else begin
      ax = e12 ? 2'd1 : 2'd2;
    end
    ins_new = 1'b1;
    for (int a = 0; a < 3; a++) begin
      g_new[a] = g[a];
      if (2'(a) == ax) begin
        g_new[a] = dir_pos[a] ? g[a] + 7'sd1 : g[a] - 7'sd1;
      end
      if (g_new[a] < 7'sd0 || g_new[a] >= $signed({1'b0, dim[a]})) begin
        ins_new = 1'b0;
      end
    end
  end

  assign query_in.ready = (state == ST_IDLE);

  // The result register loads when the walk is done and the register is free or
  // being emptied in this cycle.
  assign out_load = (state == ST_DONE) && (!out_valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !result_out.ready);
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 15'd1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (query_in.valid) begin
            state <= (query_in.command == vls_pkg::CMD_QUERY) ? ST_PREP : ST_WPRE1;
          end
        end
        ST_WPRE1: state <= ST_WPRE2;
        ST_WPRE2: state <= ST_WRITE;
        ST_WRITE: state <= ST_IDLE;
        ST_PREP:  state <= ST_EP1;
        ST_EP1:   state <= ST_EP2;
        ST_EP2:   state <= ST_EPCHK;
        ST_EPCHK: begin
          if (start_solid || rd_data) begin
            cause <= vls_pkg::CAUSE_ENDPOINT;
            state <= ST_DONE;
          end else if (s_r[0] == e_r[0] && s_r[1] == e_r[1] && s_r[2] == e_r[2]) begin
            cause <= vls_pkg::CAUSE_END;
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mcnt == 3'd5) begin
            state <= ST_WRD;
          end
        end
        ST_WRD: state <= ST_WCHK;
        ST_WCHK: begin
          if (ins && rd_data) begin
            cause <= vls_pkg::CAUSE_PATH;
            state <= ST_DONE;
          end else if (at_end) begin
            cause <= vls_pkg::CAUSE_END;
            state <= ST_DONE;
          end else if (ad[ax] == 13'd0 || !ins_new || {1'b0, ad[ax]} < n[ax]) begin
            cause <= vls_pkg::CAUSE_LEFT;
            state <= ST_DONE;
          end else begin
            state <= ST_WRD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && query_in.valid) begin
      flag_r <= query_in.solid_flag;
      idx_r  <= query_in.cell_index;
      s_r[0] <= query_in.start_x;
      s_r[1] <= query_in.start_y;
      s_r[2] <= query_in.start_z;
      e_r[0] <= query_in.end_x;
      e_r[1] <= query_in.end_y;
      e_r[2] <= query_in.end_z;
    end
    if (state == ST_PREP) begin
      for (int a = 0; a < 3; a++) begin
        g[a]  <= $signed({2'b00, s_r[a][12:8]});
        ge[a] <= e_r[a][12:8];
      end
    end
    if (state == ST_EP2) begin
      start_solid <= rd_data;
    end
    if (state == ST_EPCHK) begin
      mcnt <= 3'd0;
      for (int a = 0; a < 3; a++) begin
        dir_pos[a] <= (e_r[a] > s_r[a]);
        if (e_r[a] > s_r[a]) begin
          ad[a] <= e_r[a] - s_r[a];
          n[a]  <= 14'(ONE_CELL) - 14'(s_r[a][7:0]);
        end else if (e_r[a] < s_r[a]) begin
          ad[a] <= s_r[a] - e_r[a];
          n[a]  <= 14'(s_r[a][7:0]);
        end else begin
          ad[a] <= 13'd0;
          n[a]  <= 14'd0;
        end
      end
    end
    if (state == ST_MUL) begin
      p[mcnt] <= 27'(n[pair_a(mcnt)]) * 27'(ad[pair_b(mcnt)]);
      mcnt    <= mcnt + 3'd1;
    end
    if (state == ST_WCHK) begin
      for (int a = 0; a < 3; a++) begin
        g[a] <= g_new[a];
        if (2'(a) == ax) begin
          n[a] <= n[a] + 14'(ONE_CELL);
        end
      end
      for (int k = 0; k < 6; k++) begin
        if (pair_a(3'(k)) == ax) begin
          p[k] <= p[k] + (27'(ad[pair_b(3'(k))]) << vls_pkg::FRAC_BITS);
        end
      end
    end
    if (out_load) begin
      out_blocked <= (cause == vls_pkg::CAUSE_ENDPOINT) || (cause == vls_pkg::CAUSE_PATH);
      out_cause   <= cause;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.blocked    = out_blocked;
  assign result_out.stop_cause = out_cause;

  // The blocked flag always agrees with the stop cause.
  a_blocked_cause: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.blocked ==
      ((result_out.stop_cause == vls_pkg::CAUSE_ENDPOINT) ||
       (result_out.stop_cause == vls_pkg::CAUSE_PATH))))
    else $error("blocked flag disagrees with stop cause");

  // No word is taken while the map sweep is running.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !query_in.ready)
    else $error("input ready during map clear");

  // Map writes outside the sweep stay inside the configured grid.
  a_write_in_grid: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != ST_CLEAR) |-> ({1'b0, mem_waddr} < cells))
    else $error("map write outside grid");

endmodule
